FILE: design/cftp_pkg.sv
// package for the circle-from-three-points unit: transfer types, width and latency helpers
// depends on nothing; used by the front pipeline, the top level and the checker
`default_nettype none

package cftp_pkg;

    localparam int unsigned FIELD_BITS = 12;
    localparam int unsigned COORD_MAX  = 14;

    typedef struct packed {
        logic [FIELD_BITS-1:0] first_x;
        logic [FIELD_BITS-1:0] first_y;
        logic [FIELD_BITS-1:0] second_x;
        logic [FIELD_BITS-1:0] second_y;
        logic [FIELD_BITS-1:0] third_x;
        logic [FIELD_BITS-1:0] third_y;
    } cftp_points_t;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic [30:0]        radius;
        logic               valid_res;
    } cftp_circle_t;

    // t2*u2*v2 scaled by 2^(2*frac)
    function automatic int unsigned cftp_rad_width(input int unsigned cb, input int unsigned fb);
        return 6 * cb + 3 + 2 * fb;
    endfunction

    function automatic int unsigned cftp_root_width(input int unsigned cb, input int unsigned fb);
        return (cftp_rad_width(cb, fb) + 1) / 2;
    endfunction

    // magnitude of a scaled centre numerator
    function automatic int unsigned cftp_cnum_width(input int unsigned cb, input int unsigned fb);
        return 3 * cb + 2 + fb;
    endfunction

    function automatic int unsigned cftp_quo_width(input int unsigned cb, input int unsigned fb);
        int unsigned a;
        int unsigned b;
        a = cftp_cnum_width(cb, fb);
        b = cftp_root_width(cb, fb);
        return (a > b) ? a : b;
    endfunction

    function automatic int unsigned cftp_den_width(input int unsigned cb);
        return 2 * cb + 2;
    endfunction

    // cycles from the accepting edge to the edge that loads the result
    function automatic int unsigned cftp_latency(input int unsigned cb, input int unsigned fb);
        return 6 + cftp_root_width(cb, fb) + cftp_quo_width(cb, fb);
    endfunction

endpackage

`default_nettype wire

FILE: design/cftp_front.sv
// front pipeline: differences, cross term, squared lengths, centre numerators, radius radicand
// depends on cftp_pkg
`default_nettype none

module cftp_front #(
    parameter int unsigned COORD_BITS = 12,
    parameter int unsigned FRAC_BITS  = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  cftp_pkg::cftp_points_t points,
    output logic                 out_valid,
    output logic                 nonzero,
    output logic [COORD_BITS-1:0] x1,
    output logic [COORD_BITS-1:0] y1,
    output logic [cftp_pkg::cftp_cnum_width(COORD_BITS, FRAC_BITS)-1:0] nx_mag,
    output logic [cftp_pkg::cftp_cnum_width(COORD_BITS, FRAC_BITS)-1:0] ny_mag,
    output logic                 nx_neg,
    output logic                 ny_neg,
    output logic [cftp_pkg::cftp_den_width(COORD_BITS)-1:0] den,
    output logic [cftp_pkg::cftp_rad_width(COORD_BITS, FRAC_BITS)-1:0] rad_arg
);
    import cftp_pkg::*;

    localparam int unsigned DIF = COORD_BITS + 1;
    localparam int unsigned PW  = 2 * COORD_BITS + 2;
    localparam int unsigned SQW = 2 * COORD_BITS + 1;
    localparam int unsigned MW  = 3 * COORD_BITS + 3;
    localparam int unsigned LW  = 2 * SQW;
    localparam int unsigned XW  = cftp_rad_width(COORD_BITS, FRAC_BITS);
    localparam int unsigned CNW = cftp_cnum_width(COORD_BITS, FRAC_BITS);
    localparam int unsigned DW  = cftp_den_width(COORD_BITS);

    function automatic logic [COORD_BITS-1:0] coord(input logic [FIELD_BITS-1:0] f);
        logic [COORD_MAX-1:0] e;
        e = COORD_MAX'(f);
        return e[COORD_BITS-1:0];
    endfunction

    function automatic logic signed [DIF-1:0] diff(input logic [COORD_BITS-1:0] a,
                                                   input logic [COORD_BITS-1:0] b);
        return $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

    // stage 1
    logic                   v1_reg;
    logic [COORD_BITS-1:0]  x1_s1_reg, y1_s1_reg;
    logic signed [DIF-1:0]  tx_s1_reg, ty_s1_reg, ux_s1_reg, uy_s1_reg, vx_s1_reg, vy_s1_reg;
    logic signed [DIF-1:0]  tx_next, ty_next, ux_next, uy_next, vx_next, vy_next;
    logic [COORD_BITS-1:0]  x1_next, y1_next, x2, y2, x3, y3;

    always_comb
    begin
        x1_next = coord(points.first_x);
        y1_next = coord(points.first_y);
        x2      = coord(points.second_x);
        y2      = coord(points.second_y);
        x3      = coord(points.third_x);
        y3      = coord(points.third_y);
        tx_next = diff(x2, x1_next);
        ty_next = diff(y2, y1_next);
        ux_next = diff(x3, x1_next);
        uy_next = diff(y3, y1_next);
        vx_next = diff(x3, x2);
        vy_next = diff(y3, y2);
    end

    // stage 2
    logic                   v2_reg;
    logic [COORD_BITS-1:0]  x1_s2_reg, y1_s2_reg;
    logic signed [DIF-1:0]  tx_s2_reg, ty_s2_reg, ux_s2_reg, uy_s2_reg;
    logic signed [PW-1:0]   pa_reg, pb_reg, stx_reg, sty_reg, sux_reg, suy_reg, svx_reg, svy_reg;
    logic signed [PW-1:0]   pa_next, pb_next, stx_next, sty_next, sux_next, suy_next;
    logic signed [PW-1:0]   svx_next, svy_next;

    always_comb
    begin
        pa_next  = PW'(tx_s1_reg) * PW'(uy_s1_reg);
        pb_next  = PW'(ty_s1_reg) * PW'(ux_s1_reg);
        stx_next = PW'(tx_s1_reg) * PW'(tx_s1_reg);
        sty_next = PW'(ty_s1_reg) * PW'(ty_s1_reg);
        sux_next = PW'(ux_s1_reg) * PW'(ux_s1_reg);
        suy_next = PW'(uy_s1_reg) * PW'(uy_s1_reg);
        svx_next = PW'(vx_s1_reg) * PW'(vx_s1_reg);
        svy_next = PW'(vy_s1_reg) * PW'(vy_s1_reg);
    end

    // stage 3
    logic                   v3_reg;
    logic [COORD_BITS-1:0]  x1_s3_reg, y1_s3_reg;
    logic signed [DIF-1:0]  tx_s3_reg, ty_s3_reg, ux_s3_reg, uy_s3_reg;
    logic signed [PW-1:0]   w_s3_reg, w_next;
    logic [SQW-1:0]         t2_reg, u2_reg, v2_s3_reg, t2_next, u2_next, v2_next;

    always_comb
    begin
        w_next  = pa_reg - pb_reg;
        t2_next = SQW'($unsigned(stx_reg) + $unsigned(sty_reg));
        u2_next = SQW'($unsigned(sux_reg) + $unsigned(suy_reg));
        v2_next = SQW'($unsigned(svx_reg) + $unsigned(svy_reg));
    end

    // stage 4
    logic                   v4_reg;
    logic [COORD_BITS-1:0]  x1_s4_reg, y1_s4_reg;
    logic signed [PW-1:0]   w_s4_reg;
    logic [SQW-1:0]         v2_s4_reg;
    logic signed [MW-1:0]   m1_reg, m2_reg, m3_reg, m4_reg;
    logic signed [MW-1:0]   m1_next, m2_next, m3_next, m4_next;
    logic [LW-1:0]          m5_reg, m5_next;

    always_comb
    begin
        m1_next = MW'(uy_s3_reg) * MW'($signed({1'b0, t2_reg}));
        m2_next = MW'(ty_s3_reg) * MW'($signed({1'b0, u2_reg}));
        m3_next = MW'(tx_s3_reg) * MW'($signed({1'b0, u2_reg}));
        m4_next = MW'(ux_s3_reg) * MW'($signed({1'b0, t2_reg}));
        m5_next = LW'(t2_reg) * LW'(u2_reg);
    end

    // stage 5
    logic                   v5_reg;
    logic [COORD_BITS-1:0]  x1_s5_reg, y1_s5_reg;
    logic signed [MW-1:0]   nx_reg, ny_reg, nx_next, ny_next;
    logic [LW-1:0]          pl_reg, ph_reg, pl_next, ph_next;
    logic [DW-1:0]          d_s5_reg, d_next;
    logic                   nz_s5_reg, nz_next;
    logic                   wn_s5_reg;
    logic signed [PW-1:0]   wa;

    always_comb
    begin
        nx_next = m1_reg - m2_reg;
        ny_next = m3_reg - m4_reg;
        pl_next = LW'(m5_reg[SQW-1:0]) * LW'(v2_s4_reg);
        ph_next = LW'(m5_reg[LW-1:SQW]) * LW'(v2_s4_reg);
        wa      = w_s4_reg[PW-1] ? -w_s4_reg : w_s4_reg;
        d_next  = {wa[DW-2:0], 1'b0};
        nz_next = (w_s4_reg != '0);
    end

    // stage 6
    logic                   v6_reg;
    logic [COORD_BITS-1:0]  x1_s6_reg, y1_s6_reg;
    logic [CNW-1:0]         nxm_reg, nym_reg, nxm_next, nym_next;
    logic                   nxn_reg, nyn_reg;
    logic [DW-1:0]          d_s6_reg;
    logic                   nz_s6_reg;
    logic [XW-1:0]          x_reg, x_next;
    logic signed [MW-1:0]   nxa, nya;

    always_comb
    begin
        nxa      = nx_reg[MW-1] ? -nx_reg : nx_reg;
        nya      = ny_reg[MW-1] ? -ny_reg : ny_reg;
        nxm_next = CNW'(nxa[MW-2:0]) << FRAC_BITS;
        nym_next = CNW'(nya[MW-2:0]) << FRAC_BITS;
        x_next   = ((XW'(ph_reg) << SQW) + XW'(pl_reg)) << (2 * FRAC_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x1_s1_reg <= x1_next;
        y1_s1_reg <= y1_next;
        tx_s1_reg <= tx_next;
        ty_s1_reg <= ty_next;
        ux_s1_reg <= ux_next;
        uy_s1_reg <= uy_next;
        vx_s1_reg <= vx_next;
        vy_s1_reg <= vy_next;

        x1_s2_reg <= x1_s1_reg;
        y1_s2_reg <= y1_s1_reg;
        tx_s2_reg <= tx_s1_reg;
        ty_s2_reg <= ty_s1_reg;
        ux_s2_reg <= ux_s1_reg;
        uy_s2_reg <= uy_s1_reg;
        pa_reg    <= pa_next;
        pb_reg    <= pb_next;
        stx_reg   <= stx_next;
        sty_reg   <= sty_next;
        sux_reg   <= sux_next;
        suy_reg   <= suy_next;
        svx_reg   <= svx_next;
        svy_reg   <= svy_next;

        x1_s3_reg <= x1_s2_reg;
        y1_s3_reg <= y1_s2_reg;
        tx_s3_reg <= tx_s2_reg;
        ty_s3_reg <= ty_s2_reg;
        ux_s3_reg <= ux_s2_reg;
        uy_s3_reg <= uy_s2_reg;
        w_s3_reg  <= w_next;
        t2_reg    <= t2_next;
        u2_reg    <= u2_next;
        v2_s3_reg <= v2_next;

        x1_s4_reg <= x1_s3_reg;
        y1_s4_reg <= y1_s3_reg;
        w_s4_reg  <= w_s3_reg;
        v2_s4_reg <= v2_s3_reg;
        m1_reg    <= m1_next;
        m2_reg    <= m2_next;
        m3_reg    <= m3_next;
        m4_reg    <= m4_next;
        m5_reg    <= m5_next;

        x1_s5_reg <= x1_s4_reg;
        y1_s5_reg <= y1_s4_reg;
        nx_reg    <= nx_next;
        ny_reg    <= ny_next;
        pl_reg    <= pl_next;
        ph_reg    <= ph_next;
        d_s5_reg  <= d_next;
        nz_s5_reg <= nz_next;
        wn_s5_reg <= w_s4_reg[PW-1];

        x1_s6_reg <= x1_s5_reg;
        y1_s6_reg <= y1_s5_reg;
        nxm_reg   <= nxm_next;
        nym_reg   <= nym_next;
        // quotient sign from numerator and cross term
        nxn_reg   <= nx_reg[MW-1] ^ wn_s5_reg;
        nyn_reg   <= ny_reg[MW-1] ^ wn_s5_reg;
        d_s6_reg  <= d_s5_reg;
        nz_s6_reg <= nz_s5_reg;
        x_reg     <= x_next;
    end

    assign out_valid = v6_reg;
    assign nonzero   = nz_s6_reg;
    assign x1        = x1_s6_reg;
    assign y1        = y1_s6_reg;
    assign nx_mag    = nxm_reg;
    assign ny_mag    = nym_reg;
    assign nx_neg    = nxn_reg;
    assign ny_neg    = nyn_reg;
    assign den       = d_s6_reg;
    assign rad_arg   = x_reg;

endmodule

`default_nettype wire

FILE: design/cftp_isqrt.sv
// pipelined integer square root, one root bit per stage, with a sideband that travels along
// depends on nothing outside this file
`default_nettype none

module cftp_isqrt #(
    parameter int unsigned XW = 91,
    parameter int unsigned PW = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic [XW-1:0]           radicand,
    input  logic [PW-1:0]           in_side,
    output logic                    out_valid,
    output logic [(XW+1)/2-1:0]     root,
    output logic [PW-1:0]           out_side
);
    localparam int unsigned SW = (XW + 1) / 2;
    localparam int unsigned XE = 2 * SW;
    localparam int unsigned RW = SW + 3;

    logic          v_reg [SW];
    logic [XE-1:0] x_reg [SW];
    logic [SW-1:0] q_reg [SW];
    logic [RW-1:0] r_reg [SW];
    logic [PW-1:0] s_reg [SW];

    for (genvar i = 0; i < SW; i++)
    begin : g_stage
        logic          src_v;
        logic [XE-1:0] src_x;
        logic [SW-1:0] src_q;
        logic [RW-1:0] src_r;
        logic [PW-1:0] src_s;
        logic [RW-1:0] r_sh, trial, r_next;
        logic [SW-1:0] q_next;
        logic [XE-1:0] x_next;
        logic          ge;

        if (i == 0)
        begin : g_head
            assign src_v = in_valid;
            assign src_x = XE'(radicand);
            assign src_q = '0;
            assign src_r = '0;
            assign src_s = in_side;
        end
        else
        begin : g_body
            assign src_v = v_reg[i-1];
            assign src_x = x_reg[i-1];
            assign src_q = q_reg[i-1];
            assign src_r = r_reg[i-1];
            assign src_s = s_reg[i-1];
        end

        always_comb
        begin
            r_sh   = {src_r[RW-3:0], src_x[XE-1:XE-2]};
            trial  = RW'({src_q, 2'b01});
            ge     = (r_sh >= trial);
            r_next = ge ? (r_sh - trial) : r_sh;
            q_next = {src_q[SW-2:0], ge};
            x_next = {src_x[XE-3:0], 2'b00};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else
            begin
                v_reg[i] <= src_v;
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[i] <= x_next;
            q_reg[i] <= q_next;
            r_reg[i] <= r_next;
            s_reg[i] <= src_s;
        end
    end

    assign out_valid = v_reg[SW-1];
    assign root      = q_reg[SW-1];
    assign out_side  = s_reg[SW-1];

endmodule

`default_nettype wire

FILE: design/cftp_div.sv
// pipelined restoring divider, one quotient bit per stage, with a sideband that travels along
// depends on nothing outside this file
`default_nettype none

module cftp_div #(
    parameter int unsigned NW = 46,
    parameter int unsigned DW = 26,
    parameter int unsigned PW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    input  logic [PW-1:0] in_side,
    output logic          out_valid,
    output logic [NW-1:0] quotient,
    output logic [DW-1:0] remainder,
    output logic [PW-1:0] out_side
);
    logic          v_reg [NW];
    logic [NW-1:0] nq_reg [NW];
    logic [DW-1:0] r_reg [NW];
    logic [DW-1:0] d_reg [NW];
    logic [PW-1:0] s_reg [NW];

    for (genvar i = 0; i < NW; i++)
    begin : g_stage
        logic          src_v;
        logic [NW-1:0] src_nq;
        logic [DW-1:0] src_r, src_d;
        logic [PW-1:0] src_s;
        logic [DW:0]   r_sh, sub;
        logic [DW-1:0] r_next;
        logic [NW-1:0] nq_next;
        logic          ge;

        if (i == 0)
        begin : g_head
            assign src_v  = in_valid;
            assign src_nq = dividend;
            assign src_r  = '0;
            assign src_d  = divisor;
            assign src_s  = in_side;
        end
        else
        begin : g_body
            assign src_v  = v_reg[i-1];
            assign src_nq = nq_reg[i-1];
            assign src_r  = r_reg[i-1];
            assign src_d  = d_reg[i-1];
            assign src_s  = s_reg[i-1];
        end

        always_comb
        begin
            r_sh    = {src_r, src_nq[NW-1]};
            sub     = r_sh - {1'b0, src_d};
            ge      = (r_sh >= {1'b0, src_d});
            r_next  = ge ? sub[DW-1:0] : r_sh[DW-1:0];
            nq_next = {src_nq[NW-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else
            begin
                v_reg[i] <= src_v;
            end
        end

        always_ff @(posedge clk)
        begin
            nq_reg[i] <= nq_next;
            r_reg[i]  <= r_next;
            d_reg[i]  <= src_d;
            s_reg[i]  <= src_s;
        end
    end

    assign out_valid = v_reg[NW-1];
    assign quotient  = nq_reg[NW-1];
    assign remainder = r_reg[NW-1];
    assign out_side  = s_reg[NW-1];

endmodule

`default_nettype wire

FILE: design/circle_from_three_points_unit.sv
// top level of the circle-from-three-points unit: front pipeline, square root, dividers, result
// depends on cftp_pkg, cftp_front, cftp_isqrt, cftp_div
//
// Takes one point triple in every cycle and gives one result per triple, in order, on done
// for a single cycle. The result register loads after six front stages, the square-root
// pipeline and the dividers, which each resolve one bit per stage; the root is S =
// (6*COORD_BITS + 4 + 2*FRAC_BITS)/2 bits wide and the dividers give Q bits, Q being the
// larger of S and 3*COORD_BITS + 2 + FRAC_BITS. busy stays low, and a result must be
// taken in the cycle it is shown. Collinear or repeated points give valid_res low with zero
// centre and radius.
`default_nettype none

module circle_from_three_points_unit #(
    parameter int unsigned COORD_BITS = 12,
    parameter int unsigned FRAC_BITS  = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  cftp_pkg::cftp_points_t points,
    output logic                   done,
    output cftp_pkg::cftp_circle_t circle
);
    import cftp_pkg::*;

    localparam int unsigned XW   = cftp_rad_width(COORD_BITS, FRAC_BITS);
    localparam int unsigned SW   = cftp_root_width(COORD_BITS, FRAC_BITS);
    localparam int unsigned CNW  = cftp_cnum_width(COORD_BITS, FRAC_BITS);
    localparam int unsigned NW   = cftp_quo_width(COORD_BITS, FRAC_BITS);
    localparam int unsigned DW   = cftp_den_width(COORD_BITS);
    localparam int unsigned CB   = COORD_BITS;
    localparam int unsigned SPW  = 1 + 2 * CB + 2 * CNW + 2 + DW;
    localparam int unsigned SUMW = (NW + 2 > 33) ? NW + 2 : 33;
    localparam int unsigned QE   = (NW > 32) ? NW : 32;

    logic           f_valid, f_nz, f_nxn, f_nyn;
    logic [CB-1:0]  f_x1, f_y1;
    logic [CNW-1:0] f_nxm, f_nym;
    logic [DW-1:0]  f_den;
    logic [XW-1:0]  f_rad;

    assign busy = 1'b0;

    cftp_front #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .points    (points),
        .out_valid (f_valid),
        .nonzero   (f_nz),
        .x1        (f_x1),
        .y1        (f_y1),
        .nx_mag    (f_nxm),
        .ny_mag    (f_nym),
        .nx_neg    (f_nxn),
        .ny_neg    (f_nyn),
        .den       (f_den),
        .rad_arg   (f_rad)
    );

    logic           s_valid;
    logic [SW-1:0]  s_root;
    logic [SPW-1:0] s_side;
    logic           s_nz, s_nxn, s_nyn;
    logic [CB-1:0]  s_x1, s_y1;
    logic [CNW-1:0] s_nxm, s_nym;
    logic [DW-1:0]  s_den;

    cftp_isqrt #(
        .XW (XW),
        .PW (SPW)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .radicand  (f_rad),
        .in_side   ({f_nz, f_x1, f_y1, f_nxm, f_nym, f_nxn, f_nyn, f_den}),
        .out_valid (s_valid),
        .root      (s_root),
        .out_side  (s_side)
    );

    assign {s_nz, s_x1, s_y1, s_nxm, s_nym, s_nxn, s_nyn, s_den} = s_side;

    logic          dx_valid, dy_valid, dr_valid;
    logic [NW-1:0] qx, qy, qr;
    logic [DW-1:0] rx, ry, rr;
    logic          dx_neg, dy_neg, dr_nz;
    logic [CB-1:0] dx_x1, dy_y1;

    cftp_div #(
        .NW (NW),
        .DW (DW),
        .PW (CB + 1)
    ) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_valid),
        .dividend  (NW'(s_nxm)),
        .divisor   (s_den),
        .in_side   ({s_nxn, s_x1}),
        .out_valid (dx_valid),
        .quotient  (qx),
        .remainder (rx),
        .out_side  ({dx_neg, dx_x1})
    );

    cftp_div #(
        .NW (NW),
        .DW (DW),
        .PW (CB + 1)
    ) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_valid),
        .dividend  (NW'(s_nym)),
        .divisor   (s_den),
        .in_side   ({s_nyn, s_y1}),
        .out_valid (dy_valid),
        .quotient  (qy),
        .remainder (ry),
        .out_side  ({dy_neg, dy_y1})
    );

    // radius is floor(isqrt(X) / d), the remainder is not needed
    cftp_div #(
        .NW (NW),
        .DW (DW),
        .PW (1)
    ) u_div_r (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_valid),
        .dividend  (NW'(s_root)),
        .divisor   (s_den),
        .in_side   (s_nz),
        .out_valid (dr_valid),
        .quotient  (qr),
        .remainder (rr),
        .out_side  (dr_nz)
    );

    function automatic logic [31:0] center(input logic [NW-1:0] q, input logic [DW-1:0] r,
                                           input logic neg, input logic [CB-1:0] base);
        logic signed [SUMW-1:0] qs;
        logic signed [SUMW-1:0] sum;
        logic [SUMW-32:0]       top;
        qs  = $signed(SUMW'(q));
        // floor on a negative quotient
        if (neg)
        begin
            qs = -(qs + $signed(SUMW'(r != '0)));
        end
        sum = qs + ($signed(SUMW'(base)) <<< FRAC_BITS);
        top = sum[SUMW-1:31];
        if ((&top) || !(|top))
        begin
            return sum[31:0];
        end
        return sum[SUMW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    logic         done_reg, done_next;
    cftp_circle_t circle_reg, circle_next;
    logic [QE-1:0] qre;

    always_comb
    begin
        qre       = QE'(qr);
        done_next = dx_valid & dy_valid & dr_valid;
        circle_next = '0;
        if (dr_nz)
        begin
            circle_next.center_x  = center(qx, rx, dx_neg, dx_x1);
            circle_next.center_y  = center(qy, ry, dy_neg, dy_y1);
            circle_next.radius    = (|qre[QE-1:31]) ? 31'h7FFF_FFFF : qre[30:0];
            circle_next.valid_res = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        circle_reg <= circle_next;
    end

    assign done   = done_reg;
    assign circle = circle_reg;

endmodule

`default_nettype wire

FILE: design/cftp_checker.sv
// port-level checker for the circle-from-three-points unit, bound to the top level
// depends on cftp_pkg and circle_from_three_points_unit
`default_nettype none

module cftp_checker #(
    parameter int unsigned COORD_BITS = 12,
    parameter int unsigned FRAC_BITS  = 4
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   start,
    input logic                   busy,
    input cftp_pkg::cftp_points_t points,
    input logic                   done,
    input cftp_pkg::cftp_circle_t circle
);
    import cftp_pkg::*;

    localparam int unsigned LAT = cftp_latency(COORD_BITS, FRAC_BITS) + 1;

    logic degenerate;
    assign degenerate = ((points.first_x == points.second_x) &&
                         (points.first_y == points.second_y)) ||
                        ((points.first_y == points.second_y) &&
                         (points.first_y == points.third_y));

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    a_done_has_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without a matching input transfer");

    a_degenerate_rejected: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(start && degenerate, LAT) |-> !circle.valid_res)
        else $error("degenerate triple reported as a circle");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !circle.valid_res |->
            (circle.center_x == '0) && (circle.center_y == '0) && (circle.radius == '0))
        else $error("rejected result carries nonzero fields");

endmodule

bind circle_from_three_points_unit cftp_checker #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
) u_cftp_checker (.*);

`default_nettype wire
